[rtl/core/burning_ship_escape_time_assert.svh]
// Assertion shorthands for the escape-time core checkers.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication.
`define BSE_ASSERT_IMP(NAME, ANT, CON) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error("escape-time core check failed");

// Next-cycle implication.
`define BSE_ASSERT_NXT(NAME, ANT, CON) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error("escape-time core check failed");

`endif

[rtl/core/bship_pkg.sv]
package bship_pkg;

    // Field widths of the pixel request and the result
    localparam int PX_W      = 9;
    localparam int COLOR_W   = 32;
    localparam int CNT_OUT_W = 16;
    localparam int ADDR_W    = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RE_ORIGIN   = 3'd0,
        CFG_IM_ORIGIN   = 3'd1,
        CFG_RE_STEP     = 3'd2,
        CFG_IM_STEP     = 3'd3,
        CFG_MAX_ITER    = 3'd4,
        CFG_COLOR_SCALE = 3'd5
    } t_cfg_idx;

    // Q4.28 arithmetic
    localparam int          FRAC_BITS = 28;
    localparam logic [63:0] ESC_Q56   = 64'h0400_0000_0000_0000;  // 4.0 in Q8.56

    // Register reset values
    localparam logic [31:0] ORIGIN_RST   = 32'hE000_0000;  // -2.0
    localparam logic [30:0] STEP_RST     = 31'd2097152;
    localparam int          MAX_ITER_RST = 64;
    localparam logic [31:0] SCALE_RST    = 32'd1;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch pixel, clear iterate
        logic calc_c;    // form c from origin and step
        logic mul;       // register the three products
        logic upd;       // advance z and the count
        logic color;     // form the pixel color
        logic load_out;  // move result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic stop;      // escaped or limit reached
    } t_dp_sts;

endpackage

[rtl/core/bship_if.sv]
interface bship_pix_if;
    logic                         valid;
    logic                         ready;
    logic [bship_pkg::PX_W-1:0]   px;
    logic [bship_pkg::PX_W-1:0]   py;

    modport source (output valid, output px, output py, input ready);
    modport sink   (input valid, input px, input py, output ready);
endinterface

interface bship_res_if;
    logic                              valid;
    logic                              ready;
    logic [bship_pkg::COLOR_W-1:0]     pixel_color;
    logic [bship_pkg::CNT_OUT_W-1:0]   iter_count;
    logic [bship_pkg::ADDR_W-1:0]      pixel_address;

    modport source (output valid, output pixel_color, output iter_count,
                    output pixel_address, input ready);
    modport sink   (input valid, input pixel_color, input iter_count,
                    input pixel_address, output ready);
endinterface

interface bship_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bship_pkg::CFG_IDX_W-1:0]    index;
    logic [bship_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/burning_ship_escape_time.sv]
// Burning Ship escape-time engine. Each pixel request (px, py) is mapped to
// c = origin + coord*step in signed Q4.28 and z <- |Re(z^2+c)| + i|Im(z^2+c)|
// is iterated from zero until |z|^2 reaches 4 or the count, which starts at
// one, reaches max_iter. The result carries the count, the color (zero when
// the limit was hit, else color_scale*count mod 2^32) and the frame-buffer
// address py*IMAGE_WIDTH+px mod 2^18. One pixel is in flight at a time; each
// pass of the loop uses one shared set of three 32x32 multipliers (products
// registered, then test and update). A pixel steps through accept, forming
// c, the loop, the color product and the result handover, which waits while
// the output register holds a result that has not been taken. The result
// sits in an output register, so a new request is taken while the previous
// result still waits. Configuration writes are always accepted and must only
// be issued while the core is idle.
module burning_ship_escape_time #(
    parameter int IMAGE_WIDTH = 512,  // frame-buffer row pitch, 1..4096
    parameter int ITER_BITS   = 16    // width of the iteration counter, 4..32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bship_pix_if.sink          i_pix,
    bship_res_if.source        o_res,
    bship_cfg_if.sink          i_cfg
);

    bship_pkg::t_dp_cmd w_cmd;
    bship_pkg::t_dp_sts w_sts;

    // Register writes go straight into the register file, so the port never back-pressures.
    assign i_cfg.ready = 1'b1;

    // Sequencer: accept, point mapping, loop, color, result handover
    bship_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Registers, point mapping, iterate, color and output register
    bship_dp #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .ITER_BITS   (ITER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_idx       (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_px            (i_pix.px),
        .i_py            (i_pix.py),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_pixel_color   (o_res.pixel_color),
        .o_iter_count    (o_res.iter_count),
        .o_pixel_address (o_res.pixel_address)
    );

endmodule

[rtl/core/bship_ctrl.sv]
module bship_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bship_pkg::t_dp_sts   i_sts,
    output bship_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POINT,
        S_MUL,
        S_UPD,
        S_COLOR,
        S_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_slot_free;

    assign w_slot_free = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc_c   = (r_state == S_POINT);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.upd      = (r_state == S_UPD) && !i_sts.stop;
        o_cmd.color    = (r_state == S_COLOR);
        o_cmd.load_out = (r_state == S_PUSH) && w_slot_free;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_POINT;
            S_POINT: n_state = S_MUL;
            S_MUL:   n_state = S_UPD;
            S_UPD:   n_state = i_sts.stop ? S_COLOR : S_MUL;
            S_COLOR: n_state = S_PUSH;
            S_PUSH:  if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

[rtl/core/bship_dp.sv]
module bship_dp #(
    parameter int IMAGE_WIDTH = 512,
    parameter int ITER_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write
    input  logic                                  i_cfg_we,
    input  logic [bship_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bship_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel request
    input  logic [bship_pkg::PX_W-1:0]            i_px,
    input  logic [bship_pkg::PX_W-1:0]            i_py,
    // control
    input  bship_pkg::t_dp_cmd                    i_cmd,
    output bship_pkg::t_dp_sts                    o_sts,
    // result register
    output logic [bship_pkg::COLOR_W-1:0]         o_pixel_color,
    output logic [bship_pkg::CNT_OUT_W-1:0]       o_iter_count,
    output logic [bship_pkg::ADDR_W-1:0]          o_pixel_address
);

    // Saturate a widened signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic fits;
        fits = (v[47:31] == '0) || (v[47:31] == '1);
        if (fits) begin
            return v[31:0];
        end
        return v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // Absolute value; the most negative code maps to the largest positive one.
    function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
        if (v == 32'sh8000_0000) begin
            return 32'sh7FFF_FFFF;
        end
        return v[31] ? -v : v;
    endfunction

    // Configuration registers
    logic signed [31:0]        r_re_origin;
    logic signed [31:0]        r_im_origin;
    logic [30:0]               r_re_step;
    logic [30:0]               r_im_step;
    logic [ITER_BITS-1:0]      r_max_iter;
    logic [31:0]               r_color_scale;
    logic [31:0]               w_mi_wide;

    // Per-pixel working registers
    logic [bship_pkg::PX_W-1:0]   r_px;
    logic [bship_pkg::PX_W-1:0]   r_py;
    logic [bship_pkg::ADDR_W-1:0] r_addr;
    logic signed [31:0]        r_cre;
    logic signed [31:0]        r_cim;
    logic signed [31:0]        r_zr;
    logic signed [31:0]        r_zi;
    logic [ITER_BITS-1:0]      r_cnt;
    logic signed [63:0]        r_rr;
    logic signed [63:0]        r_ii;
    logic signed [63:0]        r_ri;
    logic [31:0]               r_color;

    // Output register
    logic [bship_pkg::COLOR_W-1:0]   r_o_color;
    logic [bship_pkg::CNT_OUT_W-1:0] r_o_iter;
    logic [bship_pkg::ADDR_W-1:0]    r_o_addr;

    logic [31:0]               w_addr;
    logic [39:0]               w_re_off;
    logic [39:0]               w_im_off;
    logic signed [47:0]        w_cre_sum;
    logic signed [47:0]        w_cim_sum;
    logic signed [63:0]        w_rr;
    logic signed [63:0]        w_ii;
    logic signed [63:0]        w_ri;
    logic [64:0]               w_mag;
    logic                      w_esc;
    logic                      w_lim;
    logic signed [63:0]        w_dif;
    logic signed [63:0]        w_dif_sh;
    logic signed [63:0]        w_ri_sh;
    logic signed [47:0]        w_re_part;
    logic signed [47:0]        w_im_part;
    logic signed [47:0]        w_re_sum;
    logic signed [47:0]        w_im_sum;
    logic [31:0]               w_cnt32;

    // Register file
    assign w_mi_wide = {16'b0, i_cfg_data[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_origin   <= bship_pkg::ORIGIN_RST;
            r_im_origin   <= bship_pkg::ORIGIN_RST;
            r_re_step     <= bship_pkg::STEP_RST;
            r_im_step     <= bship_pkg::STEP_RST;
            r_max_iter    <= ITER_BITS'(bship_pkg::MAX_ITER_RST);
            r_color_scale <= bship_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (bship_pkg::t_cfg_idx'(i_cfg_idx))
                bship_pkg::CFG_RE_ORIGIN:   r_re_origin   <= i_cfg_data;
                bship_pkg::CFG_IM_ORIGIN:   r_im_origin   <= i_cfg_data;
                bship_pkg::CFG_RE_STEP:     r_re_step     <= i_cfg_data[30:0];
                bship_pkg::CFG_IM_STEP:     r_im_step     <= i_cfg_data[30:0];
                bship_pkg::CFG_MAX_ITER:    r_max_iter    <= w_mi_wide[ITER_BITS-1:0];
                bship_pkg::CFG_COLOR_SCALE: r_color_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Point mapping: c = origin + coord * step, saturated
    assign w_addr    = 32'(i_py) * 32'(IMAGE_WIDTH) + 32'(i_px);
    assign w_re_off  = r_px * r_re_step;
    assign w_im_off  = r_py * r_im_step;
    assign w_cre_sum = 48'(r_re_origin) + $signed({8'b0, w_re_off});
    assign w_cim_sum = 48'(r_im_origin) + $signed({8'b0, w_im_off});

    // Products of the current iterate
    assign w_rr = r_zr * r_zr;
    assign w_ii = r_zi * r_zi;
    assign w_ri = r_zr * r_zi;

    // Escape test on the registered products and limit test on the count
    assign w_mag = {1'b0, r_rr} + {1'b0, r_ii};
    assign w_esc = w_mag >= {1'b0, bship_pkg::ESC_Q56};
    assign w_lim = r_cnt >= r_max_iter;
    assign o_sts.stop = w_esc || w_lim;

    // Next iterate; arithmetic shift floors
    assign w_dif     = r_rr - r_ii;
    assign w_dif_sh  = w_dif >>> bship_pkg::FRAC_BITS;
    assign w_ri_sh   = r_ri >>> (bship_pkg::FRAC_BITS - 1);
    assign w_re_part = w_dif_sh[47:0];
    assign w_im_part = w_ri_sh[47:0];
    assign w_re_sum  = w_re_part + 48'(r_cre);
    assign w_im_sum  = w_im_part + 48'(r_cim);

    assign w_cnt32 = 32'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px   <= i_px;
            r_py   <= i_py;
            r_addr <= w_addr[bship_pkg::ADDR_W-1:0];
            r_zr   <= '0;
            r_zi   <= '0;
            r_cnt  <= ITER_BITS'(1);
        end
        if (i_cmd.calc_c) begin
            r_cre <= sat32(w_cre_sum);
            r_cim <= sat32(w_cim_sum);
        end
        if (i_cmd.mul) begin
            r_rr <= w_rr;
            r_ii <= w_ii;
            r_ri <= w_ri;
        end
        if (i_cmd.upd) begin
            r_zr  <= abs_sat(sat32(w_re_sum));
            r_zi  <= abs_sat(sat32(w_im_sum));
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.color) begin
            r_color <= (r_cnt == r_max_iter) ? 32'd0 : r_color_scale * w_cnt32;
        end
        if (i_cmd.load_out) begin
            r_o_color <= r_color;
            r_o_iter  <= w_cnt32[bship_pkg::CNT_OUT_W-1:0];
            r_o_addr  <= r_addr;
        end
    end

    assign o_pixel_color   = r_o_color;
    assign o_iter_count    = r_o_iter;
    assign o_pixel_address = r_o_addr;

endmodule

[rtl/core/bship_chk.sv]
`include "burning_ship_escape_time_assert.svh"

module bship_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [bship_pkg::COLOR_W-1:0]       i_pixel_color,
    input logic [bship_pkg::CNT_OUT_W-1:0]     i_iter_count,
    input logic [bship_pkg::ADDR_W-1:0]        i_pixel_address
);

    // A taken request keeps the core busy on the next cycle.
    `BSE_ASSERT_NXT(a_busy_after_req, i_in_valid && i_in_ready, !i_in_ready)

    // A result only appears after the core has been busy.
    `BSE_ASSERT_IMP(a_result_after_work, $rose(i_out_valid), $past(!i_in_ready))

    // Counts start at one, so a delivered count is never zero.
    `BSE_ASSERT_IMP(a_count_nonzero, i_out_valid, i_iter_count != '0)

    // A stalled result holds.
    `BSE_ASSERT_NXT(a_result_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_pixel_color) && $stable(i_iter_count)
        && $stable(i_pixel_address))

endmodule

bind burning_ship_escape_time bship_chk u_bship_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_pixel_color   (o_res.pixel_color),
    .i_iter_count    (o_res.iter_count),
    .i_pixel_address (o_res.pixel_address)
);
